### src/ple_pkg.sv
`timescale 1ns / 1ps

package ple_pkg;

  localparam int DEPTH_DEF = 128;
  localparam int WIDTH_DEF = 32;
  // width used to sign-extend words between the port and the stored width
  localparam int XW = 64;

  typedef enum logic [1:0] {
    REQ_READ   = 2'd0,
    REQ_LOCATE = 2'd1,
    REQ_INSERT = 2'd2,
    REQ_DELETE = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_POS   = 2'd1,
    STAT_OVERFLOW  = 2'd2,
    STAT_UNDERFLOW = 2'd3
  } res_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_USE,
    S_WRITE,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [7:0]         position;
    logic signed [31:0] value;
  } ple_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] element;
    logic [7:0]         found_at;
    logic [7:0]         count;
    logic               is_empty;
  } ple_rsp_t;

endpackage

### src/ple_mem.sv
`timescale 1ns / 1ps

module ple_mem
  import ple_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int WIDTH = WIDTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### src/ple_seq.sv
`timescale 1ns / 1ps

module ple_seq
  import ple_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int WIDTH = WIDTH_DEF,
  localparam int AW = $clog2(DEPTH),
  localparam int FW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ple_req_t         in_data,
  output logic             res_valid,
  input  logic             res_ready,
  output ple_rsp_t         res_data,
  output logic [AW-1:0]    rd_addr,
  input  logic [WIDTH-1:0] rd_data,
  output logic             wr_en,
  output logic [AW-1:0]    wr_addr,
  output logic [WIDTH-1:0] wr_data
);

  // compare width covering both the 8-bit position and the fill count
  localparam int CW = ((FW > 8) ? FW : 8) + 1;

  seq_state_t       state_r, state_nxt;
  req_kind_t        op_r, op_nxt;
  res_status_t      status_r, status_nxt;
  logic [AW-1:0]    src_r, src_nxt;
  logic [AW-1:0]    pm1_r, pm1_nxt;
  logic [WIDTH-1:0] val_r, val_nxt;
  logic [WIDTH-1:0] elem_r, elem_nxt;
  logic [FW-1:0]    found_r, found_nxt;
  logic [FW-1:0]    fill_r, fill_nxt;

  logic              acc;
  req_kind_t         kind_in;
  logic [CW-1:0]     pos_c, fill_c;
  logic              pos_zero, beyond, beyond_ins, full, empty;
  logic [AW-1:0]     pm1_in;
  logic              append;
  logic              chk_fail;
  res_status_t       chk_status;
  logic signed [XW-1:0] val_x;
  logic [FW-1:0]     src_p1;
  logic              last, match, at_pos;
  logic signed [WIDTH-1:0] elem_s;
  logic signed [XW-1:0]    elem_x;

  assign in_ready   = (state_r == S_IDLE);
  assign acc        = in_valid && in_ready;
  assign kind_in    = req_kind_t'(in_data.req_type);
  assign pos_c      = CW'(in_data.position);
  assign fill_c     = CW'(fill_r);
  assign pos_zero   = (in_data.position == 8'd0);
  assign beyond     = (pos_c > fill_c);
  assign beyond_ins = (pos_c > (fill_c + CW'(1)));
  assign full       = (fill_r == FW'(DEPTH));
  assign empty      = (fill_r == '0);
  assign pm1_in     = AW'(pos_c - CW'(1));
  assign append     = (FW'(pm1_in) == fill_r);
  assign val_x      = XW'(in_data.value);

  // shared index unit
  assign src_p1 = FW'(src_r) + FW'(1);
  assign last   = (src_p1 == fill_r);
  assign at_pos = (src_r == pm1_r);
  assign match  = (rd_data == val_r);

  // request checks, in the order they take priority
  always_comb begin
    chk_fail   = 1'b0;
    chk_status = STAT_OK;
    unique case (kind_in)
      REQ_READ: begin
        if (pos_zero || beyond) begin
          chk_fail   = 1'b1;
          chk_status = STAT_BAD_POS;
        end
      end
      REQ_LOCATE: begin
        chk_fail = empty;
      end
      REQ_INSERT: begin
        priority if (full) begin
          chk_fail   = 1'b1;
          chk_status = STAT_OVERFLOW;
        end else if (pos_zero || beyond_ins) begin
          chk_fail   = 1'b1;
          chk_status = STAT_BAD_POS;
        end
      end
      REQ_DELETE: begin
        priority if (empty) begin
          chk_fail   = 1'b1;
          chk_status = STAT_UNDERFLOW;
        end else if (pos_zero || beyond) begin
          chk_fail   = 1'b1;
          chk_status = STAT_BAD_POS;
        end
      end
      default: begin
        chk_fail = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          priority if (chk_fail) state_nxt = S_DONE;
          else if (kind_in == REQ_INSERT && append) state_nxt = S_WRITE;
          else state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: state_nxt = S_USE;
      S_USE: begin
        unique case (op_r)
          REQ_READ:   state_nxt = S_DONE;
          REQ_LOCATE: state_nxt = (match || last) ? S_DONE : S_ISSUE;
          REQ_INSERT: state_nxt = at_pos ? S_WRITE : S_ISSUE;
          REQ_DELETE: state_nxt = last ? S_DONE : S_ISSUE;
          default:    state_nxt = S_DONE;
        endcase
      end
      S_WRITE: state_nxt = S_DONE;
      S_DONE: begin
        if (res_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    op_nxt     = op_r;
    status_nxt = status_r;
    src_nxt    = src_r;
    pm1_nxt    = pm1_r;
    val_nxt    = val_r;
    elem_nxt   = elem_r;
    found_nxt  = found_r;
    fill_nxt   = fill_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          op_nxt     = kind_in;
          status_nxt = chk_status;
          pm1_nxt    = pm1_in;
          val_nxt    = val_x[WIDTH-1:0];
          elem_nxt   = '0;
          found_nxt  = '0;
          unique case (kind_in)
            REQ_LOCATE: src_nxt = '0;
            REQ_INSERT: src_nxt = AW'(fill_r - FW'(1));
            default:    src_nxt = pm1_in;
          endcase
        end
      end
      S_USE: begin
        unique case (op_r)
          REQ_READ: elem_nxt = rd_data;
          REQ_LOCATE: begin
            if (match) found_nxt = src_p1;
            src_nxt = AW'(src_p1);
          end
          REQ_INSERT: src_nxt = src_r - AW'(1);
          REQ_DELETE: begin
            if (at_pos) elem_nxt = rd_data;
            if (last) fill_nxt = fill_r - FW'(1);
            src_nxt = AW'(src_p1);
          end
          default: ;
        endcase
      end
      S_WRITE: fill_nxt = fill_r + FW'(1);
      default: ;
    endcase
  end

  // memory port drive
  always_comb begin
    rd_addr = src_r;
    wr_en   = 1'b0;
    wr_addr = pm1_r;
    wr_data = rd_data;
    unique case (state_r)
      S_USE: begin
        if (op_r == REQ_INSERT) begin
          wr_en   = 1'b1;
          wr_addr = AW'(src_p1);
        end else if (op_r == REQ_DELETE && !at_pos) begin
          wr_en   = 1'b1;
          wr_addr = src_r - AW'(1);
        end
      end
      S_WRITE: begin
        wr_en   = 1'b1;
        wr_data = val_r;
      end
      default: ;
    endcase
  end

  assign elem_s    = elem_r;
  assign elem_x    = XW'(elem_s);
  assign res_valid = (state_r == S_DONE);

  always_comb begin
    res_data.status   = status_r;
    res_data.element  = elem_x[31:0];
    res_data.found_at = 8'(found_r);
    res_data.count    = 8'(fill_r);
    res_data.is_empty = (fill_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    status_r <= status_nxt;
    src_r    <= src_nxt;
    pm1_r    <= pm1_nxt;
    val_r    <= val_nxt;
    elem_r   <= elem_nxt;
    found_r  <= found_nxt;
  end

endmodule

### src/positional_list_engine.sv
`timescale 1ns / 1ps
// one transaction at a time; every list step goes through the memory: address
// issued, then registered read data used; read visits its position; locate scans
// up to the match; insert shifts entries from the end down to position (none for
// an append), then writes; delete shifts the later entries up; rejected requests
// go straight to the result; result then sits in the output register
// synchronous active-low reset empties the list; stored words need no clearing

module positional_list_engine
  import ple_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int WIDTH = WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ple_req_t in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output ple_rsp_t out_data
);

  localparam int AW = $clog2(DEPTH);

  logic             res_valid, res_ready;
  ple_rsp_t         res_data;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [WIDTH-1:0] rd_data, wr_data;
  logic             wr_en;

  logic     out_valid_r;
  ple_rsp_t out_data_r;

  ple_seq #(.DEPTH(DEPTH), .WIDTH(WIDTH)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  ple_mem #(.DEPTH(DEPTH), .WIDTH(WIDTH)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // output register frees the sequencer while a result waits
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("transaction accepted while previous one in flight");

  a_idle_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !res_valid)
    else $error("sequencer idle and holding a result");

  a_fail_no_element: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != STAT_OK |-> out_data.element == '0
      && out_data.found_at == '0)
    else $error("failed request returned data");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found_at != '0 |-> out_data.status == STAT_OK
      && out_data.element == '0)
    else $error("locate hit with bad status or element");

endmodule

### sim/positional_list_engine_test.sv
`timescale 1ns / 1ps

module positional_list_engine_test;
  import ple_pkg::*;

  typedef struct {
    ple_req_t rq;
    bit       drain;
  } req_slot_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  ple_req_t in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  ple_rsp_t out_data;

  req_slot_t          req_backlog[$];
  ple_rsp_t           rsp_due[$];
  logic signed [31:0] list_words[$];
  logic signed [31:0] val_pool[12];

  int gen_fill = 0;
  int n_sent = 0;
  int n_recv = 0;
  int tx_gap = 0;
  int rx_wait = 0;
  int errors = 0;

  bit tx_calm;
  bit rx_calm;

  positional_list_engine dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #30_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // stretches of back-to-back traffic on each side
  assign tx_calm = ((n_sent / 128) % 4) == 3;
  assign rx_calm = ((n_recv / 128) % 4) == 1;

  function automatic int draw_gap(bit calm);
    if (calm) return 0;
    return $urandom_range(0, 10);
  endfunction

  // applies one request to the shadow list and returns what the block should answer
  function automatic ple_rsp_t list_apply(ple_req_t rq);
    ple_rsp_t r;
    int p;
    int j;
    r = '0;
    p = int'(rq.position);
    case (req_kind_t'(rq.req_type))
      REQ_READ: begin
        if (p < 1 || p > list_words.size()) r.status = STAT_BAD_POS;
        else r.element = list_words[p-1];
      end
      REQ_LOCATE: begin
        for (j = 0; j < list_words.size(); j++) begin
          if (list_words[j] == rq.value) begin
            r.found_at = 8'(j + 1);
            break;
          end
        end
      end
      REQ_INSERT: begin
        // full list is reported before the position is looked at
        if (list_words.size() >= DEPTH_DEF) r.status = STAT_OVERFLOW;
        else if (p < 1 || p > list_words.size() + 1) r.status = STAT_BAD_POS;
        else list_words.insert(p - 1, rq.value);
      end
      default: begin
        if (list_words.size() == 0) r.status = STAT_UNDERFLOW;
        else if (p < 1 || p > list_words.size()) r.status = STAT_BAD_POS;
        else begin
          r.element = list_words[p-1];
          list_words.delete(p - 1);
        end
      end
    endcase
    r.count = 8'(list_words.size());
    r.is_empty = (list_words.size() == 0);
    return r;
  endfunction

  task automatic queue_req(req_kind_t kind, int pos, logic signed [31:0] v, bit drain);
    req_slot_t s;
    s.rq.req_type = kind;
    s.rq.position = 8'(pos);
    s.rq.value = v;
    s.drain = drain;
    req_backlog.push_back(s);
    // rough fill tracking so positions can be aimed at the live range
    if (kind == REQ_INSERT && gen_fill < DEPTH_DEF && pos >= 1 && pos <= gen_fill + 1)
      gen_fill++;
    else if (kind == REQ_DELETE && gen_fill > 0 && pos >= 1 && pos <= gen_fill)
      gen_fill--;
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    int g;
    bit took;
    req_slot_t s;
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap <= 0;
      n_sent <= 0;
    end else begin
      took = in_valid && in_ready;
      g = tx_gap;
      if (took) begin
        rsp_due.push_back(list_apply(in_data));
        n_sent <= n_sent + 1;
        g = draw_gap(tx_calm);
      end
      if (in_valid && !took) begin
        // hold the offered transaction
      end else if (g > 0) begin
        in_valid <= 1'b0;
        tx_gap <= g - 1;
      end else if (req_backlog.size() != 0 &&
                   !(req_backlog[0].drain && (took || n_sent != n_recv))) begin
        s = req_backlog.pop_front();
        in_data <= s.rq;
        in_valid <= 1'b1;
        tx_gap <= 0;
      end else begin
        in_valid <= 1'b0;
        tx_gap <= 0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    int w;
    ple_rsp_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait <= 0;
      n_recv <= 0;
    end else begin
      w = rx_wait;
      if (out_valid && out_ready) begin
        n_recv <= n_recv + 1;
        if (rsp_due.size() == 0) begin
          $error("result transaction with nothing expected");
          errors++;
        end else begin
          e = rsp_due.pop_front();
          check_field("status", 32'(e.status), 32'(out_data.status));
          check_field("element", 32'(e.element), 32'(out_data.element));
          check_field("found_at", 32'(e.found_at), 32'(out_data.found_at));
          check_field("count", 32'(e.count), 32'(out_data.count));
          check_field("is_empty", 32'(e.is_empty), 32'(out_data.is_empty));
        end
        // long hold-off so the input side backs up
        if (n_recv == 500 || n_recv == 1400) w = 400;
        else w = draw_gap(rx_calm);
      end else if (w > 0) begin
        w = w - 1;
      end
      rx_wait <= w;
      out_ready <= (w == 0);
    end
  end

  initial begin
    int n;
    int roll;
    int pos;
    int edge_hits;
    bit up;
    bit drain;
    req_kind_t kind;
    logic signed [31:0] v;

    val_pool[0] = 32'sh0000_0000;
    val_pool[1] = -32'sd1;
    val_pool[2] = 32'sh8000_0000;
    val_pool[3] = 32'sh7fff_ffff;
    val_pool[4] = 32'sd1;
    for (n = 5; n < 12; n++) val_pool[n] = $urandom;

    // directed corners
    queue_req(REQ_READ, 1, 32'sd5, 1'b0);
    queue_req(REQ_DELETE, 1, 32'sd0, 1'b0);
    queue_req(REQ_DELETE, 0, 32'sd0, 1'b0);
    queue_req(REQ_LOCATE, 0, 32'sd0, 1'b0);
    queue_req(REQ_INSERT, 0, 32'sd9, 1'b0);
    queue_req(REQ_INSERT, 2, 32'sd9, 1'b0);
    queue_req(REQ_INSERT, 1, 32'sh8000_0000, 1'b0);
    queue_req(REQ_INSERT, 2, 32'sh7fff_ffff, 1'b0);
    queue_req(REQ_INSERT, 1, -32'sd1, 1'b0);
    queue_req(REQ_INSERT, 2, 32'sd0, 1'b0);
    queue_req(REQ_INSERT, 255, 32'sd3, 1'b0);
    queue_req(REQ_READ, 0, 32'sd0, 1'b0);
    queue_req(REQ_READ, 4, 32'sd0, 1'b0);
    queue_req(REQ_READ, 5, 32'sd0, 1'b0);
    queue_req(REQ_READ, 255, -32'sd1, 1'b0);
    queue_req(REQ_LOCATE, 0, 32'sh7fff_ffff, 1'b0);
    queue_req(REQ_LOCATE, 0, 32'sd12345, 1'b0);
    queue_req(REQ_INSERT, 1, 32'sd0, 1'b0);
    queue_req(REQ_LOCATE, 0, 32'sd0, 1'b0);
    queue_req(REQ_DELETE, 0, 32'sd0, 1'b0);
    queue_req(REQ_DELETE, 6, 32'sd0, 1'b0);
    queue_req(REQ_DELETE, 5, 32'sd0, 1'b0);
    queue_req(REQ_DELETE, 1, 32'sd0, 1'b0);
    queue_req(REQ_DELETE, 2, 32'sd0, 1'b0);

    // random sweeps between empty and full
    up = 1'b1;
    edge_hits = 0;
    for (n = 0; n < 1950; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) kind = up ? REQ_INSERT : REQ_DELETE;
      else if (roll < 80) kind = up ? REQ_DELETE : REQ_INSERT;
      else if (roll < 90) kind = REQ_READ;
      else kind = REQ_LOCATE;

      if ($urandom_range(0, 9) != 0) begin
        if (kind == REQ_INSERT) pos = $urandom_range(1, gen_fill + 1);
        else pos = $urandom_range(1, (gen_fill == 0) ? 1 : gen_fill);
      end else begin
        case ($urandom_range(0, 3))
          0: pos = 0;
          1: pos = 255;
          2: pos = (kind == REQ_INSERT) ? gen_fill + 2 : gen_fill + 1;
          default: pos = $urandom_range(0, 255);
        endcase
      end

      if ((kind == REQ_INSERT || kind == REQ_LOCATE) && $urandom_range(0, 9) < 6)
        v = val_pool[$urandom_range(0, 11)];
      else
        v = $urandom;

      drain = (n == 0) || (n % 300 == 299);
      queue_req(kind, pos, v, drain);

      // linger a few requests at each extreme, then turn around
      if ((up && gen_fill == DEPTH_DEF) || (!up && gen_fill == 0)) edge_hits++;
      if (edge_hits >= 6 || $urandom_range(0, 199) == 0) begin
        up = !up;
        edge_hits = 0;
      end
    end

    do @(posedge clk);
    while (req_backlog.size() != 0 || in_valid || n_sent != n_recv);
    repeat (300) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

### files.f
src/ple_pkg.sv
src/ple_mem.sv
src/ple_seq.sv
src/positional_list_engine.sv
sim/positional_list_engine_test.sv
